/* design/pink_pkg.sv */
// Package: shared widths, function codes, filter coefficients and saturation helper.
`timescale 1ns / 1ps

package pink_pkg;

  // Field widths of the command and sample beats
  localparam int CH_FIELD_W = 3;
  localparam int SEED_W     = 32;
  localparam int SAMPLE_W   = 32;

  // Filter memories per channel
  localparam int TAPS  = 8;
  localparam int TAP_W = 3;

  // Command function codes
  localparam logic FUNC_GEN  = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  // Generator multiplier
  localparam logic signed [31:0] SEED_MULT = 32'sd282475249;

  // Q1.31 pole coefficients; the white-term and last taps have no pole
  localparam logic signed [31:0] POLE_COEF [TAPS] = '{
    32'sd2145035517, 32'sd2133138457, 32'sd2080911655, 32'sd1860795081,
    32'sd1181116006, -32'sd1635523546, 32'sd0, 32'sd0
  };

  // Q1.31 white-noise coefficients; the last entry feeds the delayed white term
  localparam logic signed [31:0] WHITE_COEF [TAPS] = '{
    32'sd119223782, 32'sd161224268, 32'sd330394654, 32'sd666762749,
    32'sd1144506135, -32'sd36288179, 32'sd1151480732, 32'sd248949189
  };

  // Clamp a 64-bit signed value to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      r = $signed(32'h8000_0000);
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* design/pink_if.sv */
// Interfaces: command channel and sample channel, valid/ready handshake.
`timescale 1ns / 1ps

interface pink_cmd_if
  import pink_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [CH_FIELD_W-1:0] channel;
  logic [SEED_W-1:0]     seed_value;

  modport source(output valid, func, channel, seed_value, input ready);
  modport sink(input valid, func, channel, seed_value, output ready);
endinterface

interface pink_smp_if
  import pink_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic [CH_FIELD_W-1:0]      out_channel;
  logic signed [SAMPLE_W-1:0] pink_sample;

  modport source(output valid, out_channel, pink_sample, input ready);
  modport sink(input valid, out_channel, pink_sample, output ready);
endinterface

/* design/pink_noise_generator.sv */
// Top level: multichannel pink noise generator, one shared multiplier over the state memories.
`timescale 1ns / 1ps

// Multichannel pink noise (refined Kellet filter, fixed point). A command beat with
// func = generate advances the channel's 32-bit multiplicative generator, runs the
// eight filter memories and returns one Q8.24 sample on the sample channel; func = load
// sets the seed (zero is stored as one) and clears the channel's memories, giving no
// sample. A channel at or above CHANNELS is dropped. A generate runs from acceptance in
// ST_IDLE through ST_SEED and ST_WHITE (generator) and 16 filter steps in ST_RUN (the
// last held while the output register is full), paced by the sixteen multiplications
// (one for the generator, fifteen for the filter) that go one per cycle through the
// single 32x32 multiplier and by the read-modify-write of one filter memory entry every
// other step. A new command is taken as soon as the previous one is done, even while
// its sample waits on the output register. Seeds and filter memories live in synchronous
// RAMs; a per-channel valid bit stands in for their reset contents.
module pink_noise_generator
  import pink_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  pink_cmd_if.sink    cmd,
  pink_smp_if.source  smp
);

  // Only channels reachable through the 3-bit field get storage
  localparam int CH_N      = (CHANNELS < 8) ? CHANNELS : 8;
  localparam int CH_W      = (CH_N > 1) ? $clog2(CH_N) : 1;
  localparam int MEM_AW    = CH_W + TAP_W;
  localparam int MEM_DEPTH = CH_N * TAPS;
  localparam int LAST_STEP = 2 * TAPS - 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_WHITE,
    ST_RUN
  } state_t;

  state_t state;
  logic [3:0] step;
  logic [CH_W-1:0] ch;
  logic [CH_FIELD_W-1:0] ch_field;
  logic signed [31:0] w;
  logic signed [63:0] prod;
  logic signed [63:0] wterm;
  logic signed [35:0] sum;
  logic [CH_N-1:0] seed_valid;
  logic [CH_N-1:0] mem_valid;
  logic out_valid;
  logic [CH_FIELD_W-1:0] out_channel;
  logic signed [31:0] out_sample;

  // State memories
  logic [31:0]        seed_mem [CH_N];
  logic signed [31:0] filter_mem [MEM_DEPTH];
  logic [31:0]        seed_rd;
  logic signed [31:0] m_rd;

  logic [CH_W-1:0] cmd_addr;
  logic in_range;
  logic accept;
  logic [TAP_W-1:0] tap;
  logic signed [31:0] seed_eff;
  logic signed [31:0] m_eff;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p;
  logic signed [63:0] acc;
  logic signed [31:0] new_m;
  logic signed [31:0] m7_new;
  logic signed [35:0] sum_fin;
  logic signed [31:0] result;
  logic finish;
  logic hold_prod;
  logic seed_we;
  logic [CH_W-1:0] seed_waddr;
  logic [31:0] seed_wdata;
  logic fm_we;
  logic [MEM_AW-1:0] fm_waddr;
  logic [MEM_AW-1:0] fm_raddr;
  logic signed [31:0] fm_wdata;

  // Handshake and channel decode
  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign cmd_addr  = cmd.channel[CH_W-1:0];
  assign in_range  = (7'(cmd.channel) < 7'(CHANNELS));

  assign smp.valid       = out_valid;
  assign smp.out_channel = out_channel;
  assign smp.pink_sample = out_sample;

  // Step position: even steps multiply by w, odd steps by the memory read
  assign tap = step[3:1];

  // Entries not yet written since reset or load read as their reset values
  assign seed_eff = seed_valid[ch] ? $signed(seed_rd) : 32'sd1;
  assign m_eff    = mem_valid[ch] ? m_rd : 32'sd0;

  // Shared multiplier operand selection
  always_comb begin
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    unique case (state)
      ST_SEED: begin
        mul_a = seed_eff;
        mul_b = SEED_MULT;
      end
      ST_RUN: begin
        if (!step[0]) begin
          mul_a = WHITE_COEF[tap];
          mul_b = w;
        end else begin
          mul_a = POLE_COEF[tap];
          mul_b = m_eff;
        end
      end
      default: begin
        mul_a = 32'sd0;
        mul_b = 32'sd0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Memory update and output arithmetic
  assign acc     = prod + wterm;
  assign new_m   = sat32(acc >>> 31);
  assign m7_new  = sat32((prod + 64'sd137438953472) >>> 38);
  assign sum_fin = sum + 36'(m_eff) + 36'sd4;
  assign result  = sat32(64'(sum_fin >>> 3));

  assign finish    = (state == ST_RUN) && (step == 4'(LAST_STEP)) && (!out_valid || smp.ready);
  assign hold_prod = (state == ST_RUN) && (step == 4'(LAST_STEP));

  // Seed memory port
  assign seed_we    = (accept && in_range && (cmd.func == FUNC_LOAD)) || (state == ST_WHITE);
  assign seed_waddr = (state == ST_IDLE) ? cmd_addr : ch;
  assign seed_wdata = (state == ST_IDLE) ?
                      ((cmd.seed_value == '0) ? 32'd1 : cmd.seed_value) : prod[31:0];

  always_ff @(posedge clk) begin
    if (seed_we) begin
      seed_mem[seed_waddr] <= seed_wdata;
    end
    seed_rd <= seed_mem[cmd_addr];
  end

  // Filter memory port: taps written back every other step, delayed term at the end
  assign fm_we    = (state == ST_RUN) && ((!step[0] && (step != 4'd0)) || finish);
  assign fm_waddr = finish ? {ch, TAP_W'(TAPS - 1)} : {ch, tap - TAP_W'(1)};
  assign fm_wdata = finish ? m7_new : new_m;
  assign fm_raddr = {ch, tap};

  always_ff @(posedge clk) begin
    if (fm_we) begin
      filter_mem[fm_waddr] <= fm_wdata;
    end
    m_rd <= filter_mem[fm_raddr];
  end

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= 4'd0;
      seed_valid <= '0;
      mem_valid  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (smp.valid && smp.ready && !finish) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && in_range) begin
            ch       <= cmd_addr;
            ch_field <= cmd.channel;
            if (cmd.func == FUNC_LOAD) begin
              seed_valid[cmd_addr] <= 1'b1;
              mem_valid[cmd_addr]  <= 1'b0;
            end else begin
              state <= ST_SEED;
            end
          end
        end
        ST_SEED: begin
          state <= ST_WHITE;
        end
        ST_WHITE: begin
          w              <= $signed(prod[31:0]);
          seed_valid[ch] <= 1'b1;
          step           <= 4'd0;
          state          <= ST_RUN;
        end
        ST_RUN: begin
          if (step == 4'd0) begin
            sum <= 36'sd0;
          end else if (!step[0]) begin
            sum <= sum + 36'(new_m);
          end else if (step != 4'(LAST_STEP)) begin
            wterm <= (prod >>> 7) + 64'sd1073741824;
          end
          if (step != 4'(LAST_STEP)) begin
            step <= step + 4'd1;
          end else if (finish) begin
            out_valid     <= 1'b1;
            out_sample    <= result;
            out_channel   <= ch_field;
            mem_valid[ch] <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Product register; held through the last step, also while it waits on the output
  always_ff @(posedge clk) begin
    if (!hold_prod) begin
      prod <= mul_p;
    end
  end

endmodule
